// ----- hw/rtl/lsbw_pkg.sv -----
package lsbw_pkg;

    typedef enum logic [1:0] {
        MODE_LD  = 2'd0,
        MODE_ST  = 2'd1,
        MODE_LDR = 2'd2,
        MODE_STR = 2'd3
    } mode_t;

    // first member in the highest bits, so mode, the last member, sits in the lowest bits
    typedef struct packed {
        logic [6:0]  offset;
        logic        decrement;
        logic        increment;
        logic        pre_adjust;
        logic        byte_access;
        logic [15:0] store_value;
        logic [15:0] base_value;
        logic [2:0]  dst_reg;
        logic [2:0]  src_reg;
        mode_t       mode;
    } item_t;

    typedef struct packed {
        logic [15:0] base_value_new;
        logic        base_write;
        logic [15:0] dest_value;
        logic        dest_write;
        logic [15:0] load_data;
        logic [15:0] effective_address;
    } result_t;

    // address generation results handed to the write-back logic
    typedef struct packed {
        logic [15:0] ea;
        logic [15:0] reg_val;
        logic [15:0] st_val;
        logic        base_write;
        logic        same_reg;
    } agu_t;

    localparam int ITEM_W     = $bits(item_t);
    localparam int RESULT_W   = $bits(result_t);
    localparam int S_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;
    localparam int ADDR_W     = 16;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    function automatic logic [15:0] adjust(input logic [15:0] v, input logic inc,
                                           input logic dec, input logic byte_acc);
        logic [15:0] step;
        logic [15:0] r;
        step = byte_acc ? 16'd1 : 16'd2;
        r    = v;
        if (inc) begin
            r = r + step;
        end
        if (dec) begin
            r = r - step;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/lsbw_mem.sv -----
module lsbw_mem #(
    parameter int DATA_WORDS = 32768,
    parameter int IDX_W      = 15
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [15:0]      rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [15:0]      wr_data,
    output logic             clr_busy
);

    logic [15:0]      mem [DATA_WORDS];
    logic [15:0]      rd_data_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] clr_cnt_next;
    logic             clr_busy_reg;
    logic             clr_busy_next;
    logic             we;
    logic [IDX_W-1:0] we_idx;
    logic [15:0]      we_data;

    // clearing sweep owns the write port until every word is zero
    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == IDX_W'(DATA_WORDS - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
        we      = clr_busy_reg | wr_en;
        we_idx  = clr_busy_reg ? clr_cnt_reg : wr_idx;
        we_data = clr_busy_reg ? 16'h0000 : wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[we_idx] <= we_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

// ----- hw/rtl/lsbw_widx.sv -----
module lsbw_widx #(
    parameter int DATA_WORDS = 32768,
    parameter int IDX_W      = 15
) (
    input  logic             aclk,
    input  logic [14:0]      word_addr,
    output logic [IDX_W-1:0] idx
);

    // word address modulo the depth by reciprocal multiply, then one correction
    localparam longint unsigned RECIP = (64'd1 << 32) / DATA_WORDS;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = 15 + RECIP_W;
    localparam int Q_W     = PROD_W - 32;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);
    localparam logic [15:0] DEPTH = 16'(DATA_WORDS);

    logic [PROD_W-1:0] prod_reg;
    logic [14:0]       addr_d_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [Q_W-1:0]    quot;
    logic [15:0]       rem;
    logic [15:0]       rem_fix;

    always_comb begin
        quot    = prod_reg[PROD_W-1:32];
        rem     = {1'b0, addr_d_reg} - 16'(quot * DEPTH);
        rem_fix = (rem >= DEPTH) ? rem - DEPTH : rem;
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= PROD_W'(word_addr) * PROD_W'(RECIP_K);
        addr_d_reg <= word_addr;
        idx_reg    <= rem_fix[IDX_W-1:0];
    end

    assign idx = idx_reg;

endmodule

// ----- hw/rtl/lsbw_agu.sv -----
module lsbw_agu (
    input  lsbw_pkg::item_t item,
    output lsbw_pkg::agu_t  agu
);
    import lsbw_pkg::*;

    logic [15:0] pre_val;
    logic [15:0] off_ext;

    always_comb begin
        pre_val = item.pre_adjust
                ? adjust(item.base_value, item.increment, item.decrement, item.byte_access)
                : item.base_value;
        off_ext = {{9{item.offset[6]}}, item.offset};

        agu.same_reg   = (item.src_reg == item.dst_reg);
        agu.reg_val    = pre_val;
        agu.base_write = 1'b0;
        agu.ea         = item.base_value + off_ext;
        agu.st_val     = item.store_value;
        if (item.mode == MODE_LD || item.mode == MODE_ST) begin
            agu.ea         = pre_val;
            agu.base_write = item.increment | item.decrement;
            // storing the address register itself stores its value after any pre-adjust
            if (agu.same_reg) begin
                agu.st_val = pre_val;
            end
        end
    end

endmodule

// ----- hw/rtl/load_store_unit_byte_word_core.sv -----
// path: an accepted word on s_ passes through S_IDX1, S_IDX2, S_READ and S_WB, and its result is registered onto m_
// flow: s_tready is high only in S_IDLE, so no new word is taken until the last has gone through
// the index reduction stages, the data memory read and the write-back, which waits on m_tready
// reset: aresetn synchronous active low; the data memory is then swept to zero,
// one word a cycle until every word is cleared, with s_tready low until it is done
module load_store_unit_byte_word_core #(
    parameter int DATA_WORDS = 32768
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // mode, src_reg, dst_reg, base_value, store_value, byte_access,
    // pre_adjust, increment, decrement, offset
    input  logic [lsbw_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // effective_address, load_data, dest_write, dest_value, base_write, base_value_new
    output logic [lsbw_pkg::M_TDATA_W-1:0]  m_tdata
);
    import lsbw_pkg::*;

    localparam int IDX_W = $clog2(DATA_WORDS);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_IDX1  = 6'b000100,
        S_IDX2  = 6'b001000,
        S_READ  = 6'b010000,
        S_WB    = 6'b100000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    item_t            item_reg;
    agu_t             agu;
    result_t          out_reg;
    result_t          res;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [IDX_W-1:0] idx;
    logic [15:0]      rd_word;
    logic             clr_busy;
    logic             wb_fire;
    logic             wr_en;
    logic [15:0]      wr_word;
    logic [15:0]      ld_val;
    logic [15:0]      reg_fin;

    lsbw_agu u_agu (
        .item (item_reg),
        .agu  (agu)
    );

    lsbw_widx #(
        .DATA_WORDS (DATA_WORDS),
        .IDX_W      (IDX_W)
    ) u_widx (
        .aclk      (aclk),
        .word_addr (agu.ea[15:1]),
        .idx       (idx)
    );

    lsbw_mem #(
        .DATA_WORDS (DATA_WORDS),
        .IDX_W      (IDX_W)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (state_reg == S_READ),
        .rd_idx   (idx),
        .rd_data  (rd_word),
        .wr_en    (wr_en),
        .wr_idx   (idx),
        .wr_data  (wr_word),
        .clr_busy (clr_busy)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign wb_fire  = (state_reg == S_WB) && (!m_tvalid_reg || m_tready);

    // write-back: load extract, store merge and register results
    always_comb begin
        if (item_reg.byte_access) begin
            ld_val = agu.ea[0] ? {BYTE_ZERO, rd_word[15:8]} : {BYTE_ZERO, rd_word[7:0]};
        end else begin
            ld_val = rd_word;
        end

        if (!item_reg.byte_access) begin
            wr_word = agu.st_val;
        end else if (agu.ea[0]) begin
            wr_word = {agu.st_val[7:0], rd_word[7:0]};
        end else begin
            wr_word = {rd_word[15:8], agu.st_val[7:0]};
        end

        reg_fin = agu.reg_val;
        wr_en   = 1'b0;
        res     = '0;
        res.effective_address = agu.ea;
        res.base_value_new    = item_reg.base_value;
        unique case (item_reg.mode)
            MODE_LD: begin
                // loaded value overrides a pre-adjust when base and destination coincide
                if (agu.same_reg) begin
                    reg_fin = ld_val;
                end
                if (!item_reg.pre_adjust) begin
                    reg_fin = adjust(reg_fin, item_reg.increment, item_reg.decrement,
                                     item_reg.byte_access);
                end
                res.load_data      = ld_val;
                res.dest_write     = 1'b1;
                res.dest_value     = agu.same_reg ? reg_fin : ld_val;
                res.base_write     = agu.base_write;
                res.base_value_new = reg_fin;
            end
            MODE_ST: begin
                if (!item_reg.pre_adjust) begin
                    reg_fin = adjust(reg_fin, item_reg.increment, item_reg.decrement,
                                     item_reg.byte_access);
                end
                wr_en              = wb_fire;
                res.base_write     = agu.base_write;
                res.base_value_new = reg_fin;
            end
            MODE_LDR: begin
                res.load_data  = ld_val;
                res.dest_write = 1'b1;
                res.dest_value = ld_val;
            end
            MODE_STR: begin
                wr_en = wb_fire;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (!clr_busy) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_IDX1;
                end
            end
            S_IDX1: state_next = S_IDX2;
            S_IDX2: state_next = S_READ;
            S_READ: state_next = S_WB;
            S_WB: begin
                if (wb_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase

        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (wb_fire) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_t'(s_tdata[ITEM_W-1:0]);
        end
        if (wb_fire) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

endmodule
